### design/deadline_timer_table_assert.svh
// Assertion macros for the deadline timer table
`ifndef DEADLINE_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_ASSERT_SVH
// Check that a condition implies a consequence at the same edge
`define DTT_ASSERT_IMP(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence at the next edge
`define DTT_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Types and constants shared by the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;
  localparam int TableDepth = 16;
  localparam int TimeWidth  = 48;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] FN_SCHED  = 3'd0;
  localparam logic [2:0] FN_CANCEL = 3'd1;
  localparam logic [2:0] FN_TAKEC  = 3'd2;
  localparam logic [2:0] FN_TAKEA  = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef struct packed {
    logic [15:0]          request_id;
    logic [7:0]           unit_id;
    logic [15:0]          frame_id;
    logic [15:0]          node_id;
    logic [15:0]          activation_id;
    logic [7:0]           attempt_id;
    logic [TimeWidth-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [2:0]           func;
    logic [15:0]          request_id;
    logic [7:0]           unit_id;
    logic [15:0]          frame_id;
    logic [TimeWidth-1:0] now;
  } probe_t;

  typedef struct packed {
    logic            dup;
    logic            unit_hit;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic            hit_found;
    logic [IdxW-1:0] hit_idx;
    logic [TimeWidth-1:0] best_dl;
  } scan_t;
endpackage

### design/dtt_if.sv
// ----------------------------------------------------------------------------
// dtt_cmd_if / dtt_rsp_if
// Valid/ready channels for the deadline timer table.
// ----------------------------------------------------------------------------
interface dtt_cmd_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [15:0]        request_id;
  logic [7:0]         unit_id;
  logic [15:0]        frame_id;
  logic [15:0]        node_id;
  logic [15:0]        activation_id;
  logic [7:0]         attempt_id;
  logic signed [31:0] duration_ms;
  logic [47:0]        time_now;
  modport source (output valid, func, request_id, unit_id, frame_id, node_id,
                  activation_id, attempt_id, duration_ms, time_now, input ready);
  modport sink (input valid, func, request_id, unit_id, frame_id, node_id,
                activation_id, attempt_id, duration_ms, time_now, output ready);
endinterface

interface dtt_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_request_id;
  logic [7:0]  out_unit_id;
  logic [15:0] out_frame_id;
  logic [15:0] out_node_id;
  logic [15:0] out_activation_id;
  logic [7:0]  out_attempt_id;
  logic [47:0] finish_time;
  logic [4:0]  pending_count;
  modport source (output valid, status, out_request_id, out_unit_id, out_frame_id,
                  out_node_id, out_activation_id, out_attempt_id, finish_time,
                  pending_count, input ready);
  modport sink (input valid, status, out_request_id, out_unit_id, out_frame_id,
                out_node_id, out_activation_id, out_attempt_id, finish_time,
                pending_count, output ready);
endinterface

### design/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table
// Table of pending timers with schedule, cancel, take and query commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: one beat per command (func plus payload), taken on valid && ready.
//   rsp: exactly one beat per command with status, taken entry and count.
//   A command is held while a scan beat walks the row of slot cells, one
//   cell per cycle, over all TableDepth cells; a commit state then
//   updates the table and registers the response beat.
//   Commands are handled one at a time; the next is accepted only after
//   the response beat is taken.
//   Reset empties the table and zeroes the pending count.
//   A stalled receiver holds the response beat and blocks new commands.
// ----------------------------------------------------------------------------
module deadline_timer_table (
  input logic      clk,
  input logic      rst,
  dtt_cmd_if.sink  cmd,
  dtt_rsp_if.source rsp
);
  import dtt_pkg::*;
  `include "deadline_timer_table_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state;
  logic [IdxW:0]   pos;
  probe_t          probe;
  entry_t          new_entry;
  scan_t           acc;
  scan_t           cell_in  [TableDepth];
  scan_t           cell_out [TableDepth];
  logic            cvalid   [TableDepth];
  entry_t          centry   [TableDepth];
  logic            cwr      [TableDepth];
  logic            cclr     [TableDepth];
  logic [CntW-1:0] count;
  logic [2:0]      st;
  logic            do_wr, do_clr;
  logic [IdxW-1:0] tgt;
  logic [32:0]     dur;
  logic [TimeWidth-1:0] room, dl;
  entry_t          taken;

  assign cmd.ready = (state == S_IDLE) && !rsp.valid;

  assign dur  = cmd.duration_ms[31] ? 33'd0 : {1'b0, cmd.duration_ms};
  assign room = {TimeWidth{1'b1}} - cmd.time_now;
  assign dl   = ({{(TimeWidth-33){1'b0}}, dur} > room) ? {TimeWidth{1'b1}}
                : cmd.time_now + {{(TimeWidth-33){1'b0}}, dur};

  genvar g;
  generate
    for (g = 0; g < TableDepth; g++) begin : g_cell
      assign cell_in[g] = acc;
      assign cwr[g]  = do_wr && (tgt == IdxW'(g));
      assign cclr[g] = do_clr && (tgt == IdxW'(g));
      dtt_cell u_cell (
        .clk(clk), .rst(rst), .idx(IdxW'(g)), .wr(cwr[g]), .wr_entry(new_entry),
        .clr(cclr[g]), .probe(probe), .scan_in(cell_in[g]), .scan_out(cell_out[g]),
        .valid(cvalid[g]), .entry(centry[g])
      );
    end
  endgenerate

  always_comb begin
    st = ST_NONE;
    do_wr = 1'b0;
    do_clr = 1'b0;
    tgt = acc.hit_idx;
    unique case (probe.func)
      FN_SCHED: begin
        if (probe.request_id == '0) st = ST_INVALID;
        else if (acc.dup) st = ST_DUP;
        else if (!acc.free_found) st = ST_FULL;
        else begin
          st = ST_OK;
          do_wr = 1'b1;
          tgt = acc.free_idx;
        end
      end
      FN_CANCEL: begin
        if (probe.request_id != '0 && acc.dup) begin
          st = ST_OK;
          do_clr = 1'b1;
        end
      end
      FN_TAKEC, FN_TAKEA: begin
        if (acc.hit_found) begin
          st = ST_OK;
          do_clr = 1'b1;
        end
      end
      FN_QUERY: begin
        if (acc.unit_hit) st = ST_OK;
      end
      default: st = ST_NONE;
    endcase
    if (state != S_DONE) begin
      do_wr = 1'b0;
      do_clr = 1'b0;
    end
    taken = centry[acc.hit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp.valid <= 1'b0;
      pos <= '0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            state <= S_SCAN;
            pos <= '0;
          end
        end
        S_SCAN: begin
          pos <= pos + 1'b1;
          if (pos == (IdxW+1)'(TableDepth - 1)) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
          rsp.valid <= 1'b1;
          if (do_wr) count <= count + 1'b1;
          else if (do_clr) count <= count - 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid && cmd.ready) begin
      probe.func       <= cmd.func;
      probe.request_id <= cmd.request_id;
      probe.unit_id    <= cmd.unit_id;
      probe.frame_id   <= cmd.frame_id;
      probe.now        <= cmd.time_now;
      new_entry.request_id    <= cmd.request_id;
      new_entry.unit_id       <= cmd.unit_id;
      new_entry.frame_id      <= cmd.frame_id;
      new_entry.node_id       <= cmd.node_id;
      new_entry.activation_id <= cmd.activation_id;
      new_entry.attempt_id    <= cmd.attempt_id;
      new_entry.deadline      <= dl;
      acc <= '0;
    end else if (state == S_SCAN) begin
      acc <= cell_out[pos[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      rsp.status <= st;
      rsp.pending_count <= 5'(do_wr ? count + 1'b1 : (do_clr ? count - 1'b1 : count));
      if (st == ST_OK && (probe.func == FN_TAKEC || probe.func == FN_TAKEA)) begin
        rsp.out_request_id    <= taken.request_id;
        rsp.out_unit_id       <= taken.unit_id;
        rsp.out_frame_id      <= taken.frame_id;
        rsp.out_node_id       <= taken.node_id;
        rsp.out_activation_id <= taken.activation_id;
        rsp.out_attempt_id    <= taken.attempt_id;
        rsp.finish_time       <= probe.now;
      end else begin
        rsp.out_request_id    <= '0;
        rsp.out_unit_id       <= '0;
        rsp.out_frame_id      <= '0;
        rsp.out_node_id       <= '0;
        rsp.out_activation_id <= '0;
        rsp.out_attempt_id    <= '0;
        rsp.finish_time       <= '0;
      end
    end
  end

  `DTT_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !cmd.ready)
  `DTT_ASSERT_NEXT(a_done_rsp, state == S_DONE, rsp.valid)
  `DTT_ASSERT_IMP(a_count_range, 1'b1, count <= CntW'(TableDepth))
  `DTT_ASSERT_IMP(a_clr_live, do_clr, cvalid[tgt])
endmodule

### design/dtt_cell.sv
// ----------------------------------------------------------------------------
// dtt_cell
// One timer slot: holds an entry and folds its own match into the scan beat
// that passes through toward the next cell.
// ----------------------------------------------------------------------------
module dtt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [dtt_pkg::IdxW-1:0] idx,
  input  logic                 wr,
  input  dtt_pkg::entry_t      wr_entry,
  input  logic                 clr,
  input  dtt_pkg::probe_t      probe,
  input  dtt_pkg::scan_t       scan_in,
  output dtt_pkg::scan_t       scan_out,
  output logic                 valid,
  output dtt_pkg::entry_t      entry
);
  import dtt_pkg::*;

  logic live, expired, ctx_ok, better;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= wr_entry;
    end
  end

  assign live    = valid;
  assign expired = live && (entry.deadline <= probe.now);
  assign ctx_ok  = (probe.func != FN_TAKEC) ||
                   (entry.unit_id == probe.unit_id && entry.frame_id == probe.frame_id);
  assign better  = expired && ctx_ok && (!scan_in.hit_found || entry.deadline < scan_in.best_dl);

  always_comb begin
    scan_out = scan_in;
    if (live && entry.request_id == probe.request_id) begin
      scan_out.dup = 1'b1;
      if (!scan_in.dup && probe.func == FN_CANCEL) scan_out.hit_idx = idx;
    end
    if (live && entry.unit_id == probe.unit_id) scan_out.unit_hit = 1'b1;
    if (!live && !scan_in.free_found) begin
      scan_out.free_found = 1'b1;
      scan_out.free_idx   = idx;
    end
    if ((probe.func == FN_TAKEC || probe.func == FN_TAKEA) && better) begin
      scan_out.hit_found = 1'b1;
      scan_out.hit_idx   = idx;
      scan_out.best_dl   = entry.deadline;
    end
  end
endmodule

### test/dtt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtt_checker
// Watches the command and response channels of the deadline timer table,
// keeps its own copy of the timer table, predicts each response and compares
// it field by field with the response that arrives.
// ----------------------------------------------------------------------------
module dtt_checker (
  input  logic     clk,
  input  logic     rst,
  dtt_cmd_if.sink  cmd,
  dtt_rsp_if.sink  rsp,
  output int       fail_count,
  output int       rsp_pending
);
  import dtt_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] request_id;
    logic [7:0]  unit_id;
    logic [15:0] frame_id;
    logic [15:0] node_id;
    logic [15:0] activation_id;
    logic [7:0]  attempt_id;
    logic [47:0] finish_time;
    logic [4:0]  pending_count;
  } timer_rsp_t;

  logic       tbl_live [TableDepth];
  entry_t     tbl_entry [TableDepth];
  logic [4:0] tbl_count;
  timer_rsp_t rsp_queue [$];

  function automatic int lookup_handle(logic [15:0] rid);
    for (int i = 0; i < TableDepth; i++)
      if (tbl_live[i] && tbl_entry[i].request_id == rid) return i;
    return -1;
  endfunction

  function automatic timer_rsp_t apply_command(
      logic [2:0] fn, logic [15:0] rid, logic [7:0] unit, logic [15:0] frame,
      logic [15:0] node, logic [15:0] act, logic [7:0] att,
      logic signed [31:0] dur, logic [47:0] now);
    timer_rsp_t r;
    int sel;
    logic [48:0] sum;
    r = '0;
    r.status = ST_NONE;
    sel = -1;
    case (fn)
      FN_SCHED: begin
        if (rid == 0) r.status = ST_INVALID;
        else if (lookup_handle(rid) >= 0) r.status = ST_DUP;
        else begin
          for (int i = 0; i < TableDepth; i++)
            if (!tbl_live[i] && sel < 0) sel = i;
          if (sel < 0) r.status = ST_FULL;
          else begin
            sum = {1'b0, now} + (dur < 0 ? 49'd0 : {17'd0, dur});
            tbl_entry[sel].request_id    = rid;
            tbl_entry[sel].unit_id       = unit;
            tbl_entry[sel].frame_id      = frame;
            tbl_entry[sel].node_id       = node;
            tbl_entry[sel].activation_id = act;
            tbl_entry[sel].attempt_id    = att;
            tbl_entry[sel].deadline      = sum[48] ? '1 : sum[47:0];
            tbl_live[sel] = 1'b1;
            tbl_count++;
            r.status = ST_OK;
          end
        end
      end
      FN_CANCEL: begin
        sel = lookup_handle(rid);
        if (rid != 0 && sel >= 0) begin
          tbl_live[sel] = 1'b0;
          tbl_count--;
          r.status = ST_OK;
        end
      end
      FN_TAKEC, FN_TAKEA: begin
        for (int i = 0; i < TableDepth; i++) begin
          if (!tbl_live[i] || tbl_entry[i].deadline > now) continue;
          if (fn == FN_TAKEC && (tbl_entry[i].unit_id != unit ||
                                 tbl_entry[i].frame_id != frame)) continue;
          if (sel < 0 || tbl_entry[i].deadline < tbl_entry[sel].deadline) sel = i;
        end
        if (sel >= 0) begin
          r.request_id    = tbl_entry[sel].request_id;
          r.unit_id       = tbl_entry[sel].unit_id;
          r.frame_id      = tbl_entry[sel].frame_id;
          r.node_id       = tbl_entry[sel].node_id;
          r.activation_id = tbl_entry[sel].activation_id;
          r.attempt_id    = tbl_entry[sel].attempt_id;
          r.finish_time   = now;
          tbl_live[sel] = 1'b0;
          tbl_count--;
          r.status = ST_OK;
        end
      end
      FN_QUERY: begin
        for (int i = 0; i < TableDepth; i++)
          if (tbl_live[i] && tbl_entry[i].unit_id == unit) r.status = ST_OK;
      end
      default: ;
    endcase
    r.pending_count = tbl_count;
    return r;
  endfunction

  assign rsp_pending = rsp_queue.size();

  always @(posedge clk) begin
    timer_rsp_t want;
    int errs;
    if (rst) begin
      for (int i = 0; i < TableDepth; i++) tbl_live[i] = 1'b0;
      tbl_count = '0;
      fail_count <= 0;
      rsp_queue.delete();
    end else begin
      errs = 0;
      if (rsp.valid && rsp.ready) begin
        if (rsp_queue.size() == 0) begin
          $error("response beat with nothing expected");
          errs++;
        end else begin
          want = rsp_queue.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp.status);
            errs++;
          end
          if (rsp.out_request_id !== want.request_id) begin
            $error("out_request_id: expected %0h actual %0h",
                   want.request_id, rsp.out_request_id);
            errs++;
          end
          if (rsp.out_unit_id !== want.unit_id) begin
            $error("out_unit_id: expected %0h actual %0h", want.unit_id, rsp.out_unit_id);
            errs++;
          end
          if (rsp.out_frame_id !== want.frame_id) begin
            $error("out_frame_id: expected %0h actual %0h",
                   want.frame_id, rsp.out_frame_id);
            errs++;
          end
          if (rsp.out_node_id !== want.node_id) begin
            $error("out_node_id: expected %0h actual %0h", want.node_id, rsp.out_node_id);
            errs++;
          end
          if (rsp.out_activation_id !== want.activation_id) begin
            $error("out_activation_id: expected %0h actual %0h",
                   want.activation_id, rsp.out_activation_id);
            errs++;
          end
          if (rsp.out_attempt_id !== want.attempt_id) begin
            $error("out_attempt_id: expected %0h actual %0h",
                   want.attempt_id, rsp.out_attempt_id);
            errs++;
          end
          if (rsp.finish_time !== want.finish_time) begin
            $error("finish_time: expected %0h actual %0h",
                   want.finish_time, rsp.finish_time);
            errs++;
          end
          if (rsp.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d actual %0d",
                   want.pending_count, rsp.pending_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cmd.valid && cmd.ready)
        rsp_queue.push_back(apply_command(cmd.func, cmd.request_id, cmd.unit_id,
            cmd.frame_id, cmd.node_id, cmd.activation_id, cmd.attempt_id,
            cmd.duration_ms, cmd.time_now));
    end
  end
endmodule

### test/tb_deadline_timer_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_table
// Drives directed and random timer commands into the deadline timer table
// with random gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_deadline_timer_table;
  import dtt_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   rsp_pending;
  logic [47:0] clock_ms;
  logic [15:0] handle_pool [8];

  dtt_cmd_if cmd (clk);
  dtt_rsp_if rsp (clk);

  deadline_timer_table dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  dtt_checker checker_i (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
                         .fail_count(fail_count), .rsp_pending(rsp_pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  task automatic send_beat(logic [2:0] fn, logic [15:0] rid, logic [7:0] unit,
                           logic [15:0] frame, logic [15:0] node, logic [15:0] act,
                           logic [7:0] att, logic signed [31:0] dur,
                           logic [47:0] now, int gap);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid         <= 1'b1;
    cmd.func          <= fn;
    cmd.request_id    <= rid;
    cmd.unit_id       <= unit;
    cmd.frame_id      <= frame;
    cmd.node_id       <= node;
    cmd.activation_id <= act;
    cmd.attempt_id    <= att;
    cmd.duration_ms   <= dur;
    cmd.time_now      <= now;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic send_simple(logic [2:0] fn, logic [15:0] rid, logic [7:0] unit,
                             logic [15:0] frame, logic signed [31:0] dur,
                             logic [47:0] now);
    send_beat(fn, rid, unit, frame, 16'($urandom), 16'($urandom), 8'($urandom),
              dur, now, 0);
  endtask

  task automatic send_random(bit dense);
    logic [2:0]  fn;
    logic [15:0] rid;
    logic [7:0]  unit;
    logic [15:0] frame;
    logic signed [31:0] dur;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) fn = FN_SCHED;
    else if (pick < 52) fn = FN_CANCEL;
    else if (pick < 70) fn = FN_TAKEC;
    else if (pick < 86) fn = FN_TAKEA;
    else if (pick < 96) fn = FN_QUERY;
    else fn = 3'($urandom_range(5, 7));
    rid   = dense ? handle_pool[$urandom_range(0, 7)] : 16'($urandom);
    unit  = dense ? 8'($urandom_range(0, 3)) : 8'($urandom);
    frame = dense ? 16'($urandom_range(0, 1)) : 16'($urandom);
    case ($urandom_range(0, 9))
      0: dur = $urandom;
      1: dur = -$signed(32'($urandom_range(0, 1000)));
      default: dur = $urandom_range(0, 60);
    endcase
    if ($urandom_range(0, 1)) clock_ms += 48'($urandom_range(0, 20));
    if ($urandom_range(0, 60) == 0) clock_ms = 48'($urandom) << 16 | 48'($urandom);
    send_beat(fn, rid, unit, frame, 16'($urandom), 16'($urandom), 8'($urandom), dur,
              clock_ms, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13));
  endtask

  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.func = '0;
    cmd.request_id = '0;
    cmd.unit_id = '0;
    cmd.frame_id = '0;
    cmd.node_id = '0;
    cmd.activation_id = '0;
    cmd.attempt_id = '0;
    cmd.duration_ms = '0;
    cmd.time_now = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_simple(FN_SCHED, 16'd0, 8'd1, 16'd1, 32'sd5, 48'd0);
    send_simple(FN_CANCEL, 16'd0, 8'd1, 16'd1, 32'sd0, 48'd0);
    send_beat(FN_SCHED, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
              32'sh7FFFFFFF, 48'hFFFF_FFFF_FF00, 0);
    send_simple(FN_SCHED, 16'hFFFF, 8'd2, 16'd2, 32'sd1, 48'd0);
    send_simple(FN_SCHED, 16'd1, 8'd0, 16'd0, -32'sd2147483648, 48'd100);
    send_simple(FN_SCHED, 16'd2, 8'd0, 16'd0, 32'sd0, 48'd100);
    send_simple(FN_QUERY, 16'd0, 8'd0, 16'd0, 32'sd0, 48'd100);
    send_simple(FN_QUERY, 16'd0, 8'd9, 16'd0, 32'sd0, 48'd100);
    send_simple(FN_TAKEC, 16'd0, 8'd0, 16'd0, 32'sd0, 48'd99);
    send_simple(FN_TAKEC, 16'd0, 8'd0, 16'd0, 32'sd0, 48'd100);
    send_simple(FN_TAKEA, 16'd0, 8'd0, 16'd0, 32'sd0, 48'd100);
    send_simple(FN_TAKEA, 16'd0, 8'd0, 16'd0, 32'sd0, 48'hFFFF_FFFF_FFFF);
    send_simple(FN_CANCEL, 16'd77, 8'd0, 16'd0, 32'sd0, 48'd0);
    send_simple(3'd5, 16'd3, 8'd0, 16'd0, 32'sd0, 48'd0);
    send_simple(3'd7, 16'd3, 8'd0, 16'd0, 32'sd0, 48'd0);
    for (int i = 0; i < 17; i++)
      send_simple(FN_SCHED, 16'(i + 10), 8'd3, 16'd3, 32'sd0, 48'd200);
    for (int i = 0; i < 17; i++)
      send_simple(FN_TAKEA, 16'd0, 8'd0, 16'd0, 32'sd0, 48'd200);

    cmd.valid <= 1'b0;
    @(posedge clk);
    while (rsp_pending != 0) @(posedge clk);

    clock_ms = 48'd1000;
    for (int n = 0; n < 1650; n++) begin
      if (n % 200 == 0)
        for (int k = 0; k < 8; k++) handle_pool[k] = 16'($urandom_range(1, 65535));
      send_random(n % 10 != 9);
    end
    cmd.valid <= 1'b0;
    @(posedge clk);

    while (rsp_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
